### hdl/soskip_pkg.sv
// ----------------------------------------------------------------------------
// soskip_pkg
// Shared types and constants for the s-expression object skipper.
// ----------------------------------------------------------------------------
`default_nettype none

package soskip_pkg;

	localparam int DEPTH_WIDTH = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef logic [DEPTH_WIDTH-1:0] depth_t;

	// byte classes handed from the front to the back
	typedef enum logic [3:0] {
		CLS_OTHER,
		CLS_WHITE,
		CLS_QUOTE,
		CLS_BSLASH,
		CLS_ATOM,
		CLS_LPAREN,
		CLS_RPAREN,
		CLS_HASH,
		CLS_EOI
	} cls_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic avail;
		cls_t cls;
	} q_head_t;

	localparam logic [2:0] OUT_STRING   = 3'd0;
	localparam logic [2:0] OUT_ATOM     = 3'd1;
	localparam logic [2:0] OUT_LIST     = 3'd2;
	localparam logic [2:0] OUT_EOI      = 3'd3;
	localparam logic [2:0] OUT_OVERFLOW = 3'd4;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

endpackage

`default_nettype wire

### hdl/soskip_front.sv
// ----------------------------------------------------------------------------
// soskip_front
// Accepts byte items and reduces each one to a class code for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module soskip_front (
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire logic [7:0]        byte_value,
	input  wire logic              end_of_input,
	input  wire logic              q_full,
	output logic                   push,
	output soskip_pkg::cls_t       push_cls
);

	function automatic soskip_pkg::cls_t classify(input logic [7:0] b, input logic eoi);
		soskip_pkg::cls_t c;
		c = soskip_pkg::CLS_OTHER;
		if (eoi)
			c = soskip_pkg::CLS_EOI;
		else if (b == soskip_pkg::CH_SPACE ||
		         (b >= soskip_pkg::CH_TAB && b <= soskip_pkg::CH_CR))
			c = soskip_pkg::CLS_WHITE;
		else if (b == soskip_pkg::CH_QUOTE)
			c = soskip_pkg::CLS_QUOTE;
		else if (b == soskip_pkg::CH_BSLASH)
			c = soskip_pkg::CLS_BSLASH;
		else if ((b >= soskip_pkg::CH_ZERO && b <= soskip_pkg::CH_NINE) ||
		         b == soskip_pkg::CH_PLUS || b == soskip_pkg::CH_MINUS ||
		         b == soskip_pkg::CH_COLON)
			c = soskip_pkg::CLS_ATOM;
		else if (b == soskip_pkg::CH_LPAREN)
			c = soskip_pkg::CLS_LPAREN;
		else if (b == soskip_pkg::CH_RPAREN)
			c = soskip_pkg::CLS_RPAREN;
		else if (b == soskip_pkg::CH_HASH)
			c = soskip_pkg::CLS_HASH;
		return c;
	endfunction

	assign item_stall = q_full;
	assign push       = item_valid && !q_full;
	assign push_cls   = classify(byte_value, end_of_input);

endmodule

`default_nettype wire

### hdl/soskip_queue.sv
// ----------------------------------------------------------------------------
// soskip_queue
// Short FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module soskip_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  soskip_pkg::cls_t          push_cls,
	input  wire logic                 pop,
	output logic                      full,
	output soskip_pkg::q_head_t       head
);

	soskip_pkg::cls_t                      entry_q [soskip_pkg::QUEUE_DEPTH];
	logic [soskip_pkg::QPTR_W-1:0]         wr_ptr_q;
	logic [soskip_pkg::QPTR_W-1:0]         rd_ptr_q;
	logic [soskip_pkg::QPTR_W:0]           count_q;

	assign full       = (count_q == (soskip_pkg::QPTR_W+1)'(soskip_pkg::QUEUE_DEPTH));
	assign head.avail = (count_q != '0);
	assign head.cls   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

### hdl/soskip_back.sv
// ----------------------------------------------------------------------------
// soskip_back
// Scan state machine: applies classified items and registers outcomes.
// ----------------------------------------------------------------------------
`default_nettype none

module soskip_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  soskip_pkg::q_head_t       head,
	output logic                      pop,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output logic [2:0]                outcome
);

	localparam logic [2:0] MODE_IDLE        = 3'd0;
	localparam logic [2:0] MODE_STRING      = 3'd1;
	localparam logic [2:0] MODE_ATOM        = 3'd2;
	localparam logic [2:0] MODE_HASH        = 3'd3;
	localparam logic [2:0] MODE_LIST        = 3'd4;
	localparam logic [2:0] MODE_LIST_STRING = 3'd5;

	logic [2:0]             mode_q, mode_d;
	logic                   esc_q, esc_d;
	soskip_pkg::depth_t     depth_q, depth_d, depth_dec;
	logic                   res_vld;
	logic [2:0]             res_code;
	logic                   out_valid_q;
	logic [2:0]             outcome_q;

	assign pop          = head.avail && (!out_valid_q || !result_stall);
	assign depth_dec    = soskip_pkg::depth_t'(depth_q - 1'b1);
	assign result_valid = out_valid_q;
	assign outcome      = outcome_q;

	always_comb begin
		mode_d   = mode_q;
		esc_d    = esc_q;
		depth_d  = depth_q;
		res_vld  = 1'b0;
		res_code = soskip_pkg::OUT_EOI;
		if (head.cls == soskip_pkg::CLS_EOI) begin
			mode_d  = MODE_IDLE;
			esc_d   = 1'b0;
			depth_d = '0;
			res_vld = 1'b1;
		end else begin
			unique case (mode_q)
				MODE_STRING, MODE_LIST_STRING: begin
					if (head.cls == soskip_pkg::CLS_BSLASH) begin
						esc_d = !esc_q;
					end else if (head.cls == soskip_pkg::CLS_QUOTE && !esc_q) begin
						esc_d = 1'b0;
						if (mode_q == MODE_STRING) begin
							mode_d   = MODE_IDLE;
							depth_d  = '0;
							res_vld  = 1'b1;
							res_code = soskip_pkg::OUT_STRING;
						end else begin
							mode_d = MODE_LIST;
						end
					end else begin
						esc_d = 1'b0;
					end
				end
				MODE_ATOM: begin
					if (head.cls == soskip_pkg::CLS_WHITE) begin
						mode_d   = MODE_IDLE;
						esc_d    = 1'b0;
						depth_d  = '0;
						res_vld  = 1'b1;
						res_code = soskip_pkg::OUT_ATOM;
					end
				end
				MODE_HASH: begin
					mode_d = MODE_LIST;
				end
				MODE_LIST: begin
					if (head.cls == soskip_pkg::CLS_QUOTE) begin
						esc_d  = 1'b0;
						mode_d = MODE_LIST_STRING;
					end else if (head.cls == soskip_pkg::CLS_LPAREN) begin
						if (&depth_q) begin
							mode_d   = MODE_IDLE;
							esc_d    = 1'b0;
							depth_d  = '0;
							res_vld  = 1'b1;
							res_code = soskip_pkg::OUT_OVERFLOW;
						end else begin
							depth_d = soskip_pkg::depth_t'(depth_q + 1'b1);
						end
					end else if (head.cls == soskip_pkg::CLS_RPAREN) begin
						depth_d = depth_dec;
						if (depth_dec == '0) begin
							mode_d   = MODE_IDLE;
							esc_d    = 1'b0;
							res_vld  = 1'b1;
							res_code = soskip_pkg::OUT_LIST;
						end
					end
				end
				default: begin
					// idle, and the unused codes behave as idle
					mode_d = MODE_IDLE;
					esc_d  = 1'b0;
					if (head.cls == soskip_pkg::CLS_QUOTE) begin
						mode_d = MODE_STRING;
					end else if (head.cls == soskip_pkg::CLS_ATOM) begin
						mode_d = MODE_ATOM;
					end else if (head.cls == soskip_pkg::CLS_LPAREN) begin
						mode_d  = MODE_LIST;
						depth_d = soskip_pkg::depth_t'(1);
					end else if (head.cls == soskip_pkg::CLS_HASH) begin
						mode_d  = MODE_HASH;
						depth_d = soskip_pkg::depth_t'(1);
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			esc_q       <= 1'b0;
			depth_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mode_q  <= mode_d;
				esc_q   <= esc_d;
				depth_q <= depth_d;
			end
			if (pop && res_vld)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res_vld)
			outcome_q <= res_code;
	end

endmodule

`default_nettype wire

### hdl/s_expression_object_skipper_core.sv
// The completing item is registered in the queue, then its outcome in the result
// register. Throughput: one item per cycle unless result_stall holds a pending result;
// the scan state register updates once per item.
// A four-item queue absorbs result-side stalls; item_stall rises when it is full.
// Reset (arst_n low) empties the queue, clears the result valid flag and returns
// the scanner to idle with escape parity and nesting depth at zero.
// ----------------------------------------------------------------------------
// s_expression_object_skipper_core
// Finds the end of the next s-expression object in a byte stream.
// ----------------------------------------------------------------------------
`default_nettype none

module s_expression_object_skipper_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [7:0]  byte_value,
	input  wire logic        end_of_input,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [2:0]       outcome
);

	logic                    q_full;
	logic                    push;
	logic                    pop;
	soskip_pkg::cls_t        push_cls;
	soskip_pkg::q_head_t     head;

	soskip_front u_front (
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.byte_value   (byte_value),
		.end_of_input (end_of_input),
		.q_full       (q_full),
		.push         (push),
		.push_cls     (push_cls)
	);

	soskip_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cls (push_cls),
		.pop      (pop),
		.full     (q_full),
		.head     (head)
	);

	soskip_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.outcome      (outcome)
	);

endmodule

`default_nettype wire

### hdl/soskip_checker.sv
// ----------------------------------------------------------------------------
// soskip_checker
// Port-level checks on the object skipper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module soskip_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       item_valid,
	input wire logic       item_stall,
	input wire logic       result_valid,
	input wire logic       result_stall,
	input wire logic [2:0] outcome
);

	// only the five defined outcomes appear
	a_outcome_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (outcome <= soskip_pkg::OUT_OVERFLOW))
		else $error("outcome code out of range");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(outcome))
		else $error("stalled result changed");

	// the queue only fills through an accepted item
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(item_stall) |-> $past(item_valid && !item_stall))
		else $error("item_stall rose without an accepted item");

	a_result_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(result_valid) |-> !$past(result_stall))
		else $error("result withdrawn while stalled");

endmodule

bind s_expression_object_skipper_core soskip_checker u_soskip_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.outcome      (outcome)
);

`default_nettype wire
